/* rtl/bsfr_pkg.sv */
`default_nettype none

package bsfr_pkg;

   // widths of the payload fields and of the configuration port
   localparam int BYTE_WIDTH       = 8;
   localparam int LEN_WIDTH        = 16;
   localparam int COUNT_WIDTH      = 16;
   localparam int CSR_INDEX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH   = 16;

   // reset values of the configuration registers
   localparam logic [LEN_WIDTH-1:0] MIN_FRAME_LEN_RESET = 16'd68;
   localparam logic [LEN_WIDTH-1:0] MAX_FRAME_LEN_RESET = 16'd1500;

   // special line bytes
   localparam logic [BYTE_WIDTH-1:0] BYTE_END     = 8'hFF;
   localparam logic [BYTE_WIDTH-1:0] BYTE_ESC     = 8'hFE;
   localparam logic [BYTE_WIDTH-1:0] BYTE_ESC_END = 8'hFD;
   localparam logic [BYTE_WIDTH-1:0] BYTE_ESC_ESC = 8'hFC;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MIN_FRAME_LEN = 2'd0,
      CSR_MAX_FRAME_LEN = 2'd1
   } csr_index_type;

   // receiver mode
   typedef enum logic [1:0] {
      MODE_NORMAL  = 2'd0,
      MODE_ESCAPED = 2'd1,
      MODE_ERROR   = 2'd2
   } mode_type;

   // result event codes
   typedef enum logic [2:0] {
      KIND_DATA     = 3'd0,
      KIND_GOOD     = 3'd1,
      KIND_RUNT     = 3'd2,
      KIND_OVERFLOW = 3'd3,
      KIND_FRAMING  = 3'd4
   } kind_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]            event_kind;
      logic [BYTE_WIDTH-1:0] data_byte;
      logic [LEN_WIDTH-1:0]  frame_length;
   } rsp_payload_type;

endpackage

`default_nettype wire

/* rtl/bsfr_stream_if.sv */
`default_nettype none

// valid/ready channel carrying one payload per transfer
interface bsfr_stream_if #(
   parameter type PAYLOAD_TYPE = logic
) ();

   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

/* rtl/byte_stuffed_frame_receiver_core.sv */
// the result of a transferred byte is registered before it is offered on rsp
// throughput: one byte per cycle with the skid entry empty; mode and count update on transfer
// an output register and a one-entry skid register hold results while rsp stalls
// req.ready drops only while the skid register is occupied
// synchronous reset clears mode, count and both valid flags, and loads 68 and 1500
`default_nettype none

module byte_stuffed_frame_receiver_core #(
   parameter int COUNT_WIDTH = bsfr_pkg::COUNT_WIDTH
) (
   input  wire                                     clock,
   input  wire                                     reset,
   bsfr_stream_if.sink                             req,
   bsfr_stream_if.source                           rsp,
   input  wire                                     csr_wr_en,
   input  wire  [bsfr_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire  [bsfr_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);

   localparam int LW = bsfr_pkg::LEN_WIDTH;
   localparam int BW = bsfr_pkg::BYTE_WIDTH;

   logic [LW-1:0]              min_len_ff;
   logic [LW-1:0]              max_len_ff;
   bsfr_pkg::mode_type         mode_ff, mode_in;
   logic [COUNT_WIDTH-1:0]     count_ff, count_in;
   bsfr_pkg::rsp_payload_type  out_ff, out_in;
   logic                       out_valid_ff, out_valid_in;
   bsfr_pkg::rsp_payload_type  skid_ff, skid_in;
   logic                       skid_valid_ff, skid_valid_in;

   logic                       accept;
   logic [BW-1:0]              rx_byte;
   logic [LW-1:0]              count_ext;
   logic                       overflow;
   logic                       take_data;
   logic [BW-1:0]              decoded;
   logic                       res_valid;
   bsfr_pkg::rsp_payload_type  res;
   logic                       pop;
   logic                       push;

   assign accept    = req.valid && req.ready;
   assign rx_byte   = req.payload.rx_byte;
   assign count_ext = LW'(count_ff);
   assign overflow  = (count_ext >= max_len_ff) || (count_ff == '1);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= bsfr_pkg::MIN_FRAME_LEN_RESET;
         max_len_ff <= bsfr_pkg::MAX_FRAME_LEN_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            bsfr_pkg::CSR_MIN_FRAME_LEN: min_len_ff <= csr_wdata;
            bsfr_pkg::CSR_MAX_FRAME_LEN: max_len_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // byte decode: which bytes carry payload and their unstuffed value
   always_comb begin
      take_data = 1'b0;
      decoded   = rx_byte;
      unique case (mode_ff)
         bsfr_pkg::MODE_NORMAL: begin
            take_data = (rx_byte != bsfr_pkg::BYTE_ESC) && (rx_byte != bsfr_pkg::BYTE_END);
         end
         bsfr_pkg::MODE_ESCAPED: begin
            if (rx_byte == bsfr_pkg::BYTE_ESC_END) begin
               take_data = 1'b1;
               decoded   = bsfr_pkg::BYTE_END;
            end else if (rx_byte == bsfr_pkg::BYTE_ESC_ESC) begin
               take_data = 1'b1;
               decoded   = bsfr_pkg::BYTE_ESC;
            end
         end
         default: ;
      endcase
   end

   // next mode and payload count
   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      if (accept) begin
         if (take_data) begin
            if (overflow) begin
               mode_in  = bsfr_pkg::MODE_ERROR;
               count_in = '0;
            end else begin
               mode_in  = bsfr_pkg::MODE_NORMAL;
               count_in = count_ff + 1'b1;
            end
         end else begin
            unique case (mode_ff)
               bsfr_pkg::MODE_NORMAL: begin
                  if (rx_byte == bsfr_pkg::BYTE_ESC) begin
                     mode_in = bsfr_pkg::MODE_ESCAPED;
                  end else begin
                     count_in = '0;
                  end
               end
               bsfr_pkg::MODE_ESCAPED: begin
                  mode_in = bsfr_pkg::MODE_ERROR;
               end
               default: begin
                  if (rx_byte == bsfr_pkg::BYTE_END) begin
                     mode_in  = bsfr_pkg::MODE_NORMAL;
                     count_in = '0;
                  end else begin
                     mode_in = bsfr_pkg::MODE_ERROR;
                  end
               end
            endcase
         end
      end
   end

   // result of the current byte
   always_comb begin
      res_valid = 1'b0;
      res       = '0;
      if (take_data) begin
         res_valid = 1'b1;
         if (overflow) begin
            res.event_kind = bsfr_pkg::KIND_OVERFLOW;
         end else begin
            res.event_kind = bsfr_pkg::KIND_DATA;
            res.data_byte  = decoded;
         end
      end else begin
         unique case (mode_ff)
            bsfr_pkg::MODE_NORMAL: begin
               if (rx_byte == bsfr_pkg::BYTE_END && count_ff != '0) begin
                  res_valid        = 1'b1;
                  res.frame_length = count_ext;
                  res.event_kind   = (count_ext < min_len_ff) ? bsfr_pkg::KIND_RUNT
                                                              : bsfr_pkg::KIND_GOOD;
               end
            end
            bsfr_pkg::MODE_ESCAPED: begin
               res_valid      = 1'b1;
               res.event_kind = bsfr_pkg::KIND_FRAMING;
            end
            default: begin
               if (rx_byte != bsfr_pkg::BYTE_END) begin
                  res_valid      = 1'b1;
                  res.event_kind = bsfr_pkg::KIND_FRAMING;
               end
            end
         endcase
      end
   end

   // output register with skid entry
   assign pop  = !out_valid_ff || rsp.ready;
   assign push = accept && res_valid;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_in       = res;
            skid_valid_in = push;
         end else begin
            out_in        = res;
            out_valid_in  = push;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   // state and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= bsfr_pkg::MODE_NORMAL;
         count_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         count_ff      <= count_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req.ready   = !skid_valid_ff;
   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_ff;

`ifndef ASSERT_OFF
   // the skid entry is only filled behind a held output
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry occupied with empty output register");

   // an escape byte in normal mode moves to escaped mode
   assert property (@(posedge clock) disable iff (reset)
      accept && mode_ff == bsfr_pkg::MODE_NORMAL && rx_byte == bsfr_pkg::BYTE_ESC
      |=> mode_ff == bsfr_pkg::MODE_ESCAPED)
      else $error("escape byte did not enter escaped mode");

   // an end byte in error mode recovers with a cleared count
   assert property (@(posedge clock) disable iff (reset)
      accept && mode_ff == bsfr_pkg::MODE_ERROR && rx_byte == bsfr_pkg::BYTE_END
      |=> mode_ff == bsfr_pkg::MODE_NORMAL && count_ff == '0)
      else $error("end byte did not leave error mode");

   // only data events carry a data byte
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.event_kind != bsfr_pkg::KIND_DATA |-> out_ff.data_byte == '0)
      else $error("non-data event with data byte set");
`endif

endmodule

`default_nettype wire

/* verif/byte_stuffed_frame_receiver_core_tb.sv */
`timescale 1ns / 1ps

module byte_stuffed_frame_receiver_core_tb;

   // a register index that the block must ignore
   localparam logic [bsfr_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam int SETTLE_CYCLES = 4;
   localparam int LONG_STALL_CYCLES = 300;

   logic clock = 1'b0;
   logic reset;

   logic                                 csr_wr_en;
   logic [bsfr_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [bsfr_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata;

   bsfr_stream_if #(.PAYLOAD_TYPE(bsfr_pkg::req_payload_type)) req_if ();
   bsfr_stream_if #(.PAYLOAD_TYPE(bsfr_pkg::rsp_payload_type)) rsp_if ();

   // raw line bytes waiting to be offered, and decoded events still to arrive
   logic [bsfr_pkg::BYTE_WIDTH-1:0] line_bytes[$];
   bsfr_pkg::rsp_payload_type       decoded_events[$];

   // shadow of the deframer state and its registers
   bsfr_pkg::mode_type               line_mode;
   logic [bsfr_pkg::COUNT_WIDTH-1:0] frame_count;
   logic [bsfr_pkg::LEN_WIDTH-1:0]   min_len;
   logic [bsfr_pkg::LEN_WIDTH-1:0]   max_len;

   int send_idle_pct;
   int recv_idle_pct;
   logic long_stall_go;
   int stall_left;
   int error_count = 0;

   byte_stuffed_frame_receiver_core dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // append one decoded payload byte to the frame, or abort on overflow
   function automatic void accept_payload(input logic [bsfr_pkg::BYTE_WIDTH-1:0] d,
                                          output bsfr_pkg::rsp_payload_type ev);
      ev = '0;
      line_mode = bsfr_pkg::MODE_NORMAL;
      if (frame_count >= max_len || frame_count == '1) begin
         line_mode = bsfr_pkg::MODE_ERROR;
         frame_count = '0;
         ev.event_kind = bsfr_pkg::KIND_OVERFLOW;
      end else begin
         frame_count = frame_count + 1'b1;
         ev.event_kind = bsfr_pkg::KIND_DATA;
         ev.data_byte = d;
      end
   endfunction

   // advance the shadow deframer by one line byte; returns 1 when an event results
   function automatic bit unstuff_byte(input logic [bsfr_pkg::BYTE_WIDTH-1:0] c,
                                       output bsfr_pkg::rsp_payload_type ev);
      bit got;
      ev = '0;
      got = 1'b1;
      if (line_mode == bsfr_pkg::MODE_NORMAL && c == bsfr_pkg::BYTE_ESC) begin
         line_mode = bsfr_pkg::MODE_ESCAPED;
         got = 1'b0;
      end else if (line_mode == bsfr_pkg::MODE_NORMAL && c == bsfr_pkg::BYTE_END) begin
         // empty frame is padding
         if (frame_count == '0) begin
            got = 1'b0;
         end else begin
            ev.event_kind = (frame_count < min_len) ? bsfr_pkg::KIND_RUNT
                                                    : bsfr_pkg::KIND_GOOD;
            ev.frame_length = frame_count;
            frame_count = '0;
         end
      end else if (line_mode == bsfr_pkg::MODE_NORMAL) begin
         accept_payload(c, ev);
      end else if (line_mode == bsfr_pkg::MODE_ESCAPED && c == bsfr_pkg::BYTE_ESC_END) begin
         accept_payload(bsfr_pkg::BYTE_END, ev);
      end else if (line_mode == bsfr_pkg::MODE_ESCAPED && c == bsfr_pkg::BYTE_ESC_ESC) begin
         accept_payload(bsfr_pkg::BYTE_ESC, ev);
      end else if (line_mode != bsfr_pkg::MODE_ESCAPED && c == bsfr_pkg::BYTE_END) begin
         // end byte leaves error mode quietly
         line_mode = bsfr_pkg::MODE_NORMAL;
         frame_count = '0;
         got = 1'b0;
      end else begin
         // bad escape, or any byte while in error mode
         line_mode = bsfr_pkg::MODE_ERROR;
         ev.event_kind = bsfr_pkg::KIND_FRAMING;
      end
      return got;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // line byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (line_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_if.valid <= 1'b1;
            req_if.payload.rx_byte <= line_bytes.pop_front();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // event receiver, with random idling and an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left <= 0;
      end else if (long_stall_go) begin
         rsp_if.ready <= 1'b0;
         stall_left <= LONG_STALL_CYCLES;
      end else if (stall_left != 0) begin
         rsp_if.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // check events, predict from accepted bytes and track register writes
   always @(posedge clock) begin
      bsfr_pkg::rsp_payload_type seen;
      bsfr_pkg::rsp_payload_type want;
      bsfr_pkg::rsp_payload_type predicted;
      if (reset) begin
         line_mode = bsfr_pkg::MODE_NORMAL;
         frame_count = '0;
         min_len = bsfr_pkg::MIN_FRAME_LEN_RESET;
         max_len = bsfr_pkg::MAX_FRAME_LEN_RESET;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            seen = rsp_if.payload;
            if (decoded_events.size() == 0) begin
               report_mismatch("unexpected event kind", 32'(seen.event_kind), 0);
            end else begin
               want = decoded_events.pop_front();
               if (seen.event_kind !== want.event_kind)
                  report_mismatch("event_kind", 32'(seen.event_kind),
                                  32'(want.event_kind));
               if (seen.data_byte !== want.data_byte)
                  report_mismatch("data_byte", 32'(seen.data_byte), 32'(want.data_byte));
               if (seen.frame_length !== want.frame_length)
                  report_mismatch("frame_length", 32'(seen.frame_length),
                                  32'(want.frame_length));
            end
         end
         if (req_if.valid && req_if.ready) begin
            if (unstuff_byte(req_if.payload.rx_byte, predicted))
               decoded_events.push_back(predicted);
         end
         if (csr_wr_en) begin
            case (csr_index)
               bsfr_pkg::CSR_MIN_FRAME_LEN: min_len = csr_wdata;
               bsfr_pkg::CSR_MAX_FRAME_LEN: max_len = csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // one register write, done while the block is idle
   task automatic write_reg(input logic [bsfr_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [bsfr_pkg::CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // wait until every byte is taken and every event has come back
   task automatic settle();
      do
         @(negedge clock);
      while (line_bytes.size() != 0 || req_if.valid || decoded_events.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // mostly well-formed stuffed frames, with some broken escapes and noise
   task automatic queue_traffic(input int n_items, input int len_cap);
      int n;
      int len;
      int roll;
      logic [bsfr_pkg::BYTE_WIDTH-1:0] d;
      n = 0;
      while (n < n_items) begin
         roll = $urandom_range(99);
         if (roll < 80) begin
            len = $urandom_range(len_cap);
            repeat (len) begin
               d = 8'($urandom_range(255));
               if (d == bsfr_pkg::BYTE_END) begin
                  line_bytes.push_back(bsfr_pkg::BYTE_ESC);
                  line_bytes.push_back(bsfr_pkg::BYTE_ESC_END);
                  n += 2;
               end else if (d == bsfr_pkg::BYTE_ESC) begin
                  line_bytes.push_back(bsfr_pkg::BYTE_ESC);
                  line_bytes.push_back(bsfr_pkg::BYTE_ESC_ESC);
                  n += 2;
               end else begin
                  line_bytes.push_back(d);
                  n++;
               end
            end
            line_bytes.push_back(bsfr_pkg::BYTE_END);
            n++;
         end else if (roll < 90) begin
            // escape followed by anything at all
            line_bytes.push_back(bsfr_pkg::BYTE_ESC);
            line_bytes.push_back(8'($urandom_range(255)));
            n += 2;
         end else begin
            repeat ($urandom_range(1, 4)) begin
               line_bytes.push_back(8'($urandom_range(255)));
               n++;
            end
         end
      end
   endtask

   task automatic run_phase(input logic [bsfr_pkg::LEN_WIDTH-1:0] lo,
                            input logic [bsfr_pkg::LEN_WIDTH-1:0] hi,
                            input int send_pct, input int recv_pct,
                            input int n_items, input int len_cap);
      settle();
      write_reg(bsfr_pkg::CSR_MIN_FRAME_LEN, lo);
      write_reg(bsfr_pkg::CSR_MAX_FRAME_LEN, hi);
      @(posedge clock);
      send_idle_pct <= send_pct;
      recv_idle_pct <= recv_pct;
      @(negedge clock);
      queue_traffic(n_items, len_cap);
   endtask

   // stimulus sequence
   initial begin
      logic [bsfr_pkg::BYTE_WIDTH-1:0] directed[$];
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      long_stall_go = 1'b0;
      send_idle_pct = 24;
      recv_idle_pct = 54;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: padding, runt, good frame with both escapes, overflow,
      // error mode, bad escapes including escape-escape and escape-end
      write_reg(bsfr_pkg::CSR_MIN_FRAME_LEN, 16'd2);
      write_reg(bsfr_pkg::CSR_MAX_FRAME_LEN, 16'd4);
      write_reg(CSR_UNUSED_INDEX, 16'hFFFF);
      directed = '{bsfr_pkg::BYTE_END,
                   8'h00, bsfr_pkg::BYTE_END,
                   bsfr_pkg::BYTE_ESC, bsfr_pkg::BYTE_ESC_END,
                   bsfr_pkg::BYTE_ESC, bsfr_pkg::BYTE_ESC_ESC, 8'h7F, bsfr_pkg::BYTE_END,
                   8'h01, 8'h02, 8'h03, 8'h04, 8'h80,
                   bsfr_pkg::BYTE_ESC, bsfr_pkg::BYTE_END,
                   bsfr_pkg::BYTE_ESC, bsfr_pkg::BYTE_ESC, 8'h55, bsfr_pkg::BYTE_END,
                   bsfr_pkg::BYTE_ESC, bsfr_pkg::BYTE_END, bsfr_pkg::BYTE_END};
      @(negedge clock);
      foreach (directed[i]) line_bytes.push_back(directed[i]);

      // sender idles less than receiver
      run_phase(16'd0, 16'd0, 24, 54, 175, 6);
      run_phase(16'd1, 16'd8, 24, 54, 175, 12);

      // receiver idles less than sender; one long hold-off fills the block
      run_phase(16'd4, 16'd12, 54, 24, 175, 16);
      @(posedge clock);
      long_stall_go <= 1'b1;
      @(posedge clock);
      long_stall_go <= 1'b0;
      run_phase(16'hFFFF, 16'hFFFF, 54, 24, 175, 20);

      // no idling
      run_phase(16'd20, 16'd40, 0, 0, 175, 48);
      run_phase(bsfr_pkg::MIN_FRAME_LEN_RESET, bsfr_pkg::MAX_FRAME_LEN_RESET, 0, 0, 175, 80);

      settle();
      repeat (10) @(posedge clock);
      if (error_count == 0 && decoded_events.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // hang guard
   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
